[src/rdsd_pkg.sv]
package rdsd_pkg;

  localparam int unsigned NAME_LEN  = 8;
  localparam int unsigned ROW_CHARS = 4;
  localparam int unsigned TEXT_ROWS = 16;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [1:0] ERR_BAD  = 2'd3;
  localparam logic [3:0] GROUP_PS = 4'd0;
  localparam logic [3:0] GROUP_RT = 4'd2;
  // Text position 32 is the first character of row 8.
  localparam logic [3:0] ZERO_ROW = 4'd8;

  typedef enum logic [1:0] {
    ACT_DECODE    = 2'd0,
    ACT_CLEAR     = 2'd1,
    ACT_READ_NAME = 2'd2,
    ACT_READ_TEXT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IGNORED = 3'd0,
    ST_NAME    = 3'd1,
    ST_TEXT    = 3'd2,
    ST_CLEARED = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  typedef struct packed {
    logic        clr_all;
    logic        clr_text;
    logic        set_flag;
    logic        flag;
    logic        name_we;
    logic [1:0]  name_pair;
    logic [15:0] name_data;
    logic        text_we;
    logic [3:0]  text_row;
    logic [3:0]  text_be;
    logic [31:0] text_data;
    logic        zero_pos32;
  } upd_t;

  function automatic logic [7:0] map_char(input logic [7:0] c);
    map_char = (c == CHAR_CR) ? 8'h00 : c;
  endfunction

endpackage

[src/rdsd_dec.sv]
module rdsd_dec
  import rdsd_pkg::*;
(
  input  action_t     action,
  input  logic [15:0] block_b,
  input  logic [15:0] block_c,
  input  logic [15:0] block_d,
  input  logic [1:0]  err_b,
  input  logic [1:0]  err_c,
  input  logic [1:0]  err_d,
  input  logic        ab_flag,
  input  logic        ab_known,
  output upd_t        upd,
  output status_t     status,
  output logic        message_changed,
  output logic [5:0]  write_position
);

  logic [3:0] gtype;
  logic       ver_b;
  logic       flag;
  logic [3:0] seg;
  logic [7:0] c_hi, c_lo, d_hi, d_lo;
  logic       chg;

  assign gtype = block_b[15:12];
  assign ver_b = block_b[11];
  assign flag  = block_b[4];
  assign seg   = block_b[3:0];
  assign c_hi  = map_char(block_c[15:8]);
  assign c_lo  = map_char(block_c[7:0]);
  assign d_hi  = map_char(block_d[15:8]);
  assign d_lo  = map_char(block_d[7:0]);
  assign chg   = !ab_known || (flag != ab_flag);

  always_comb begin
    upd             = '0;
    status          = ST_IGNORED;
    message_changed = 1'b0;
    write_position  = '0;
    unique case (action)
      ACT_CLEAR: begin
        upd.clr_all = 1'b1;
        status      = ST_CLEARED;
      end
      ACT_READ_NAME, ACT_READ_TEXT: begin
        status = ST_READ;
      end
      default: begin
        if (err_b != ERR_BAD && err_d != ERR_BAD) begin
          if (gtype == GROUP_PS) begin
            upd.name_we    = 1'b1;
            upd.name_pair  = seg[1:0];
            upd.name_data  = {d_lo, d_hi};
            status         = ST_NAME;
            write_position = {3'b000, seg[1:0], 1'b0};
          end else if (gtype == GROUP_RT) begin
            if (chg) begin
              upd.clr_text    = 1'b1;
              upd.set_flag    = 1'b1;
              upd.flag        = flag;
              message_changed = 1'b1;
            end
            if (!ver_b) begin
              if (err_c != ERR_BAD) begin
                upd.text_we    = 1'b1;
                upd.text_row   = seg;
                upd.text_be    = 4'b1111;
                upd.text_data  = {d_lo, d_hi, c_lo, c_hi};
                status         = ST_TEXT;
                write_position = {seg, 2'b00};
              end
            end else begin
              upd.text_we    = 1'b1;
              upd.text_row   = {1'b0, seg[3:1]};
              upd.text_be    = seg[0] ? 4'b1100 : 4'b0011;
              upd.text_data  = {d_lo, d_hi, d_lo, d_hi};
              upd.zero_pos32 = 1'b1;
              status         = ST_TEXT;
              write_position = {1'b0, seg, 1'b0};
            end
          end
        end
      end
    endcase
  end

endmodule

[src/rds_station_name_and_text_decoder.sv]
// A request in the input register moves its result into the output register once that is empty
// or out_tready is high. Throughput: one request per cycle unless stalled; the stores update
// as a request leaves the input register, so the next request already sees the new contents.
// Only a held result stalls the input: with both registers full, in_tready follows out_tready.
// Reset (rst_n low, synchronous) clears both stores, the A/B flag and its known
// bit, and empties both pipeline registers.
module rds_station_name_and_text_decoder
  import rdsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] block_b, [31:16] block_c, [47:32] block_d, [49:48] err_b,
  // [51:50] err_c, [53:52] err_d, [59:54] read_index, [63:60] zero
  input  logic [63:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] message_changed, [6:1] write_position, [14:7] read_char, [15] zero
  output logic [15:0] out_tdata,
  // [2:0] status
  output logic [2:0]  out_tuser
);

  logic        s1_vld_r;
  logic [63:0] s1_data_r;
  action_t     s1_act_r;
  logic        out_vld_r;
  logic [15:0] out_data_r;
  logic [2:0]  out_user_r;
  logic        adv;

  logic [7:0]  name_r [NAME_LEN];
  logic [7:0]  name_nxt [NAME_LEN];
  logic [31:0] text_r [TEXT_ROWS];
  logic [31:0] text_nxt [TEXT_ROWS];
  logic        ab_flag_r, ab_flag_nxt;
  logic        ab_known_r, ab_known_nxt;

  upd_t        upd;
  status_t     status;
  logic        msg_chg;
  logic [5:0]  wr_pos;
  logic [5:0]  rd_idx;
  logic [31:0] rd_row;
  logic [7:0]  rd_text;
  logic [7:0]  rd_char;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;

  rdsd_dec u_dec (
    .action          (s1_act_r),
    .block_b         (s1_data_r[15:0]),
    .block_c         (s1_data_r[31:16]),
    .block_d         (s1_data_r[47:32]),
    .err_b           (s1_data_r[49:48]),
    .err_c           (s1_data_r[51:50]),
    .err_d           (s1_data_r[53:52]),
    .ab_flag         (ab_flag_r),
    .ab_known        (ab_known_r),
    .upd             (upd),
    .status          (status),
    .message_changed (msg_chg),
    .write_position  (wr_pos)
  );

  assign rd_idx  = s1_data_r[59:54];
  assign rd_row  = text_r[rd_idx[5:2]];
  assign rd_text = rd_row[{rd_idx[1:0], 3'b000} +: 8];

  always_comb begin
    case (s1_act_r)
      ACT_READ_NAME: rd_char = (rd_idx[5:3] == 3'b000) ? name_r[rd_idx[2:0]] : 8'h00;
      ACT_READ_TEXT: rd_char = rd_text;
      default:       rd_char = 8'h00;
    endcase
  end

  always_comb begin
    ab_flag_nxt  = ab_flag_r;
    ab_known_nxt = ab_known_r;
    for (int i = 0; i < NAME_LEN; i++) begin
      name_nxt[i] = name_r[i];
    end
    for (int r = 0; r < TEXT_ROWS; r++) begin
      text_nxt[r] = text_r[r];
    end
    if (s1_vld_r && adv) begin
      if (upd.clr_all) begin
        ab_known_nxt = 1'b0;
        for (int i = 0; i < NAME_LEN; i++) begin
          name_nxt[i] = 8'h00;
        end
      end
      if (upd.set_flag) begin
        ab_flag_nxt  = upd.flag;
        ab_known_nxt = 1'b1;
      end
      if (upd.name_we) begin
        name_nxt[{upd.name_pair, 1'b0}] = upd.name_data[7:0];
        name_nxt[{upd.name_pair, 1'b1}] = upd.name_data[15:8];
      end
      for (int r = 0; r < TEXT_ROWS; r++) begin
        if (upd.clr_all || upd.clr_text) begin
          text_nxt[r] = '0;
        end
        if (upd.text_we && upd.text_row == 4'(r)) begin
          for (int k = 0; k < ROW_CHARS; k++) begin
            if (upd.text_be[k]) begin
              text_nxt[r][k*8 +: 8] = upd.text_data[k*8 +: 8];
            end
          end
        end
        if (upd.zero_pos32 && ZERO_ROW == 4'(r)) begin
          text_nxt[r][7:0] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      ab_flag_r  <= 1'b0;
      ab_known_r <= 1'b0;
      for (int i = 0; i < NAME_LEN; i++) begin
        name_r[i] <= 8'h00;
      end
      for (int r = 0; r < TEXT_ROWS; r++) begin
        text_r[r] <= '0;
      end
    end else begin
      ab_flag_r  <= ab_flag_nxt;
      ab_known_r <= ab_known_nxt;
      for (int i = 0; i < NAME_LEN; i++) begin
        name_r[i] <= name_nxt[i];
      end
      for (int r = 0; r < TEXT_ROWS; r++) begin
        text_r[r] <= text_nxt[r];
      end
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_act_r  <= action_t'(in_tuser);
    end
    if (adv && s1_vld_r) begin
      out_data_r <= {1'b0, rd_char, wr_pos, msg_chg};
      out_user_r <= status;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[sim/rds_decode_checker.sv]
module rds_decode_checker
  import rdsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t    status;
    logic       msg_changed;
    logic [5:0] write_pos;
    logic [7:0] read_char;
  } decode_result_t;

  logic [7:0] name_chars [NAME_LEN];
  logic [7:0] text_chars [64];
  logic       ab_flag;
  logic       ab_known;

  decode_result_t expected_results [$];

  function automatic logic [7:0] strip_cr(input logic [7:0] c);
    return (c == CHAR_CR) ? 8'h00 : c;
  endfunction

  function automatic void clear_text();
    foreach (text_chars[i]) text_chars[i] = 8'h00;
  endfunction

  function automatic decode_result_t decode_request(input action_t act,
                                                    input logic [63:0] data);
    decode_result_t res;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [1:0]  eb;
    logic [1:0]  ec;
    logic [1:0]  ed;
    logic [5:0]  idx;
    logic [5:0]  pos;
    b   = data[15:0];
    c   = data[31:16];
    d   = data[47:32];
    eb  = data[49:48];
    ec  = data[51:50];
    ed  = data[53:52];
    idx = data[59:54];
    res.status      = ST_IGNORED;
    res.msg_changed = 1'b0;
    res.write_pos   = 6'd0;
    res.read_char   = 8'h00;
    case (act)
      ACT_CLEAR: begin
        foreach (name_chars[i]) name_chars[i] = 8'h00;
        clear_text();
        ab_known   = 1'b0;
        res.status = ST_CLEARED;
      end
      ACT_READ_NAME: begin
        res.status    = ST_READ;
        res.read_char = (idx < NAME_LEN) ? name_chars[idx[2:0]] : 8'h00;
      end
      ACT_READ_TEXT: begin
        res.status    = ST_READ;
        res.read_char = text_chars[idx];
      end
      default: begin
        if (eb == ERR_BAD || ed == ERR_BAD) return res;
        if (b[15:12] == GROUP_PS) begin
          pos = {3'd0, b[1:0], 1'b0};
          name_chars[pos]     = strip_cr(d[15:8]);
          name_chars[pos + 1] = strip_cr(d[7:0]);
          res.status    = ST_NAME;
          res.write_pos = pos;
        end else if (b[15:12] == GROUP_RT) begin
          if (!ab_known || b[4] != ab_flag) begin
            clear_text();
            ab_flag         = b[4];
            ab_known        = 1'b1;
            res.msg_changed = 1'b1;
          end
          if (!b[11]) begin
            // Version A needs block C for its first two characters.
            if (ec == ERR_BAD) return res;
            pos = {b[3:0], 2'b00};
            text_chars[pos]     = strip_cr(c[15:8]);
            text_chars[pos + 1] = strip_cr(c[7:0]);
            text_chars[pos + 2] = strip_cr(d[15:8]);
            text_chars[pos + 3] = strip_cr(d[7:0]);
          end else begin
            pos = {1'b0, b[3:0], 1'b0};
            text_chars[pos]     = strip_cr(d[15:8]);
            text_chars[pos + 1] = strip_cr(d[7:0]);
            text_chars[32]      = 8'h00;
          end
          res.status    = ST_TEXT;
          res.write_pos = pos;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    decode_result_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      foreach (name_chars[i]) name_chars[i] = 8'h00;
      clear_text();
      ab_flag  = 1'b0;
      ab_known = 1'b0;
      expected_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding: status %0d, data %h",
                 out_tuser, out_tdata);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tuser !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
            errs++;
          end
          if (out_tdata[0] !== exp_res.msg_changed) begin
            $error("message_changed: expected %0d, got %0d",
                   exp_res.msg_changed, out_tdata[0]);
            errs++;
          end
          if (out_tdata[6:1] !== exp_res.write_pos) begin
            $error("write_position: expected %0d, got %0d",
                   exp_res.write_pos, out_tdata[6:1]);
            errs++;
          end
          if (out_tdata[14:7] !== exp_res.read_char) begin
            $error("read_char: expected %h, got %h", exp_res.read_char, out_tdata[14:7]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(decode_request(action_t'(in_tuser), in_tdata));
      fail_count <= fail_count + errs;
      pending    <= expected_results.size();
    end
  end

endmodule

[sim/tb_rds_station_name_and_text_decoder.sv]
module tb_rds_station_name_and_text_decoder;

  import rdsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_GROUPS = 250;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  int   fail_count;
  int   pending;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic text_flag = 1'b0;

  always #2 clk = ~clk;

  rds_station_name_and_text_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rds_decode_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(input action_t act, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d,
                              input logic [1:0] eb, input logic [1:0] ec,
                              input logic [1:0] ed, input logic [5:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'd0, idx, ed, ec, eb, d, c, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    return ($urandom_range(0, 9) == 0) ? CHAR_CR : 8'($urandom);
  endfunction

  function automatic logic [1:0] random_err();
    return ($urandom_range(0, 9) == 0) ? ERR_BAD : 2'($urandom_range(0, 2));
  endfunction

  task automatic send_random_request();
    int          pick;
    logic [15:0] b;
    logic [5:0]  idx;
    pick = $urandom_range(0, 99);
    b    = 16'($urandom);
    idx  = 6'($urandom);
    if (pick < 72) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        b[15:12] = GROUP_PS;
      end else if (pick < 85) begin
        b[15:12] = GROUP_RT;
        b[11]    = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 9) == 0) text_flag = ~text_flag;
        b[4] = text_flag;
      end
      send_request(ACT_DECODE, b, {random_char(), random_char()},
                   {random_char(), random_char()}, random_err(), random_err(),
                   random_err(), idx);
    end else if (pick < 84) begin
      if ($urandom_range(0, 1) == 0) idx[5:3] = 3'd0;
      send_request(ACT_READ_NAME, b, 16'($urandom), 16'($urandom), 2'($urandom),
                   2'($urandom), 2'($urandom), idx);
    end else if (pick < 97) begin
      send_request(ACT_READ_TEXT, b, 16'($urandom), 16'($urandom), 2'($urandom),
                   2'($urandom), 2'($urandom), idx);
    end else begin
      send_request(ACT_CLEAR, b, 16'($urandom), 16'($urandom), 2'($urandom),
                   2'($urandom), 2'($urandom), idx);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_DECODE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ACT_READ_NAME, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd63);
    send_request(ACT_DECODE, 16'h0000, 16'h0000, {CHAR_CR, 8'h41}, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h0FFF, 16'hFFFF, 16'hFFFF, 2'd2, 2'd2, 2'd2, 6'd63);
    send_request(ACT_DECODE, 16'h0001, 16'h1234, 16'h5A0D, 2'd1, 2'd1, 2'd1, 6'd0);
    send_request(ACT_READ_NAME, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_READ_NAME, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd3);
    send_request(ACT_READ_NAME, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd7);
    send_request(ACT_READ_NAME, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd8);
    send_request(ACT_READ_NAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 2'd3, 2'd3, 6'd63);
    send_request(ACT_DECODE, 16'h2000, 16'h480D, 16'h0D49, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h200F, 16'hFFFF, 16'hFFFF, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h2011, 16'h4142, 16'h4344, 2'd0, 2'd3, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h2018, 16'h5152, 16'h5354, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h2818, 16'h0000, 16'h6162, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd32);
    send_request(ACT_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd33);
    send_request(ACT_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd16);
    send_request(ACT_DECODE, 16'h0002, 16'h0000, 16'h7A7A, 2'd3, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h2000, 16'h7A7A, 16'h7A7A, 2'd0, 2'd0, 2'd3, 6'd0);
    send_request(ACT_DECODE, 16'hF000, 16'h7A7A, 16'h7A7A, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h1003, 16'h7A7A, 16'h7A7A, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_DECODE, 16'h2811, 16'h0000, 16'h2122, 2'd0, 2'd0, 2'd0, 6'd0);
    send_request(ACT_READ_TEXT, 16'h0000, 16'h0000, 16'h0000, 2'd0, 2'd0, 2'd0, 6'd2);

    text_flag = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 88 : (phase == 3) ? 32 : 0;
      stall_pct = (phase == 2) ? 88 : (phase == 3) ? 32 : 0;
      for (int n = 0; n < PHASE_GROUPS; n++) begin
        send_random_request();
        if (phase == 2 && n == PHASE_GROUPS / 2) drain_results();
      end
    end

    idle_pct  = 0;
    stall_pct = 0;
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
